[src/dtm_pkg.sv]
// Shared constants for the integer matrix determinant block.
package dtm_pkg;
    localparam int DATA_W       = 32;
    localparam int MAX_SIZE_DEF = 8;
    localparam int LOAD_CNT_W   = 7;
    localparam int SIZE_W       = 4;
    localparam int PADDR_W      = 2;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd3;
    localparam logic [PADDR_W-1:0] ADDR_SIZE_REG = '0;
endpackage

[src/dtm_elem_mem.sv]
// Element store: simple dual-port RAM holding the loaded matrix.
module dtm_elem_mem
    import dtm_pkg::*;
#(
    parameter int DEPTH = MAX_SIZE_DEF * MAX_SIZE_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output logic [DATA_W-1:0] o_rdata
);
    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[src/dtm_minor_mem.sv]
// Minor table: determinant of each minor, indexed by the set of rows removed.
module dtm_minor_mem
    import dtm_pkg::*;
#(
    parameter int MS = MAX_SIZE_DEF
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [MS-1:0]     i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [MS-1:0]     i_raddr,
    output logic [DATA_W-1:0] o_rdata
);
    localparam int DEPTH = 1 << MS;
    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[src/integer_matrix_determinant.sv]
// Top level: element loading, minor-table sequencer and APB register.
//
//  channel   direction  handshake                    payload
//  input     in         start & !busy                i_element
//  result    out        o_done (one-cycle strobe)    o_determinant
//  config    in         psel & penable & pwrite      pwdata[3:0] -> matrix_size
//
// Loading takes an element on each accepted start beat. After the last element busy
// rises and the sequencer walks every row subset but the full set, in decreasing
// numeric order to the empty set, one minor table entry each: a removed row is skipped
// in the read state, a row that adds a term passes read, multiply and accumulate, and
// each subset ends with a write; the result strobes in the cycle after the last write.
// Reset clears the size to 3 and the load count; no clearing pass is needed.
// The receiver cannot stall; a result strobes once and is gone.
module integer_matrix_determinant
    import dtm_pkg::*;
#(
    parameter int MAX_SIZE = MAX_SIZE_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [DATA_W-1:0] i_element,
    output logic                    o_done,
    output logic signed [DATA_W-1:0] o_determinant,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [PADDR_W-1:0]      paddr,
    input  logic [DATA_W-1:0]       pwdata,
    output logic [DATA_W-1:0]       prdata,
    output logic                    pready
);
    localparam int MS  = MAX_SIZE;
    localparam int RW  = $clog2(MS);
    localparam int SZW = $clog2(MS + 1);
    localparam int AW  = $clog2(MS * MS);

    typedef enum logic [2:0] {S_LOAD, S_RD, S_MUL, S_ACC, S_WR} t_state;

    t_state            r_state;
    logic [SIZE_W-1:0] r_size;
    logic [LOAD_CNT_W-1:0] r_cnt;
    logic [MS-1:0]     r_used;
    logic [RW-1:0]     r_row;
    logic [DATA_W-1:0] r_acc, r_prod;
    logic              r_pos, r_full_hit;
    logic              r_done;
    logic [DATA_W-1:0] r_det;

    logic [SZW-1:0]    n_eff, col;
    logic [MS-1:0]     full_mask, row_bit, minor_raddr;
    logic [LOAD_CNT_W-1:0] total, idx, idx_next;
    logic [AW-1:0]     elem_raddr;
    logic [DATA_W-1:0] elem_rdata, minor_rdata, mul_b;
    logic              accept, cfg_wr, row_last, minor_we;

    function automatic logic [SZW-1:0] f_popcount(input logic [MS-1:0] v);
        logic [SZW-1:0] c;
        c = '0;
        for (int i = 0; i < MS; i++) begin
            c = c + SZW'(v[i]);
        end
        return c;
    endfunction

    always_comb begin
        if (r_size == '0) begin
            n_eff = SZW'(1);
        end else if (32'(r_size) > MS) begin
            n_eff = SZW'(MS);
        end else begin
            n_eff = SZW'(r_size);
        end
        for (int i = 0; i < MS; i++) begin
            full_mask[i] = (i < 32'(n_eff));
        end
    end

    assign total    = LOAD_CNT_W'(n_eff) * LOAD_CNT_W'(n_eff);
    assign idx      = (r_cnt >= total) ? '0 : r_cnt;
    assign idx_next = idx + LOAD_CNT_W'(1);
    assign accept   = start && !busy;
    assign cfg_wr   = psel && penable && pwrite && pready;

    assign col         = f_popcount(r_used);
    assign row_bit     = MS'(1) << r_row;
    assign minor_raddr = r_used | row_bit;
    assign elem_raddr  = AW'(r_row) * AW'(n_eff) + AW'(col);
    assign row_last    = (SZW'(r_row) + SZW'(1)) == n_eff;
    assign mul_b       = r_full_hit ? DATA_W'(1) : minor_rdata;
    assign minor_we    = (r_state == S_WR);

    dtm_elem_mem #(.DEPTH(MS * MS), .AW(AW)) u_elem (
        .i_clk  (i_clk),
        .i_we   (accept),
        .i_waddr(idx[AW-1:0]),
        .i_wdata(i_element),
        .i_raddr(elem_raddr),
        .o_rdata(elem_rdata)
    );

    dtm_minor_mem #(.MS(MS)) u_minor (
        .i_clk  (i_clk),
        .i_we   (minor_we),
        .i_waddr(r_used),
        .i_wdata(r_acc),
        .i_raddr(minor_raddr),
        .o_rdata(minor_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_size  <= SIZE_RESET;
            r_cnt   <= '0;
            r_done  <= 1'b0;
            r_det   <= '0;
        end else begin
            r_done <= 1'b0;
            if (cfg_wr) begin
                r_size <= pwdata[SIZE_W-1:0];
            end
            unique case (r_state)
                S_LOAD: begin
                    if (accept) begin
                        if (idx_next == total) begin
                            r_cnt   <= '0;
                            r_used  <= full_mask - MS'(1);
                            r_row   <= '0;
                            r_acc   <= '0;
                            r_pos   <= 1'b0;
                            r_state <= S_RD;
                        end else begin
                            // a size write drops the partial matrix
                            r_cnt <= cfg_wr ? '0 : idx_next;
                        end
                    end else if (cfg_wr) begin
                        r_cnt <= '0;
                    end
                end
                S_RD: begin
                    if (r_used[r_row]) begin
                        if (row_last) begin
                            r_state <= S_WR;
                        end else begin
                            r_row <= r_row + RW'(1);
                        end
                    end else begin
                        r_full_hit <= (minor_raddr == full_mask);
                        r_state    <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= elem_rdata * mul_b;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_acc <= r_pos ? (r_acc - r_prod) : (r_acc + r_prod);
                    r_pos <= !r_pos;
                    if (row_last) begin
                        r_state <= S_WR;
                    end else begin
                        r_row   <= r_row + RW'(1);
                        r_state <= S_RD;
                    end
                end
                S_WR: begin
                    if (r_used == '0) begin
                        r_done  <= 1'b1;
                        r_det   <= r_acc;
                        r_state <= S_LOAD;
                    end else begin
                        r_used  <= r_used - MS'(1);
                        r_row   <= '0;
                        r_acc   <= '0;
                        r_pos   <= 1'b0;
                        r_state <= S_RD;
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign busy          = (r_state != S_LOAD);
    assign o_done        = r_done;
    assign o_determinant = r_det;
    assign pready        = 1'b1;
    assign prdata        = (paddr == ADDR_SIZE_REG) ?
                           {{(DATA_W-SIZE_W){1'b0}}, r_size} : '0;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy) else $error("result strobe while busy");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("result strobe repeated");
    a_busy_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start)) else $error("busy without a start beat");
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |-> (SZW'(r_row) < n_eff)) else $error("row past size");
endmodule
